@@ hdl/vta_pkg.sv @@
package vta_pkg;

    // Fixed field widths of the stream and configuration ports.
    localparam int NUM_AXES  = 3;
    localparam int REL_W     = 16;
    localparam int POS_W     = 32;
    localparam int CFG_W     = 60;
    localparam int CFG_IDX_W = 2;

    typedef logic [REL_W-1:0] rel_t;
    typedef rel_t [NUM_AXES-1:0] rel_vec_t;
    typedef logic [POS_W-1:0] pos_t;
    typedef pos_t [NUM_AXES-1:0] pos_vec_t;
    typedef logic [1:0] pos_kind_t;
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    // Position kinds carried in tuser.
    localparam pos_kind_t KIND_CONTINUE = 2'd0;
    localparam pos_kind_t KIND_NEW_ROW  = 2'd1;
    localparam pos_kind_t KIND_ORIGIN   = 2'd2;

    // Configuration register indexes.
    localparam cfg_idx_t CFG_IDX_COL_X = 2'd0;
    localparam cfg_idx_t CFG_IDX_COL_Y = 2'd1;
    localparam cfg_idx_t CFG_IDX_COL_Z = 2'd2;

    // Control handed to the accumulator with each transformed item.
    typedef struct packed {
        logic      load;
        pos_kind_t kind;
    } acc_ctl_t;

endpackage

@@ hdl/vta_column.sv @@
module vta_column #(
    parameter int COEF_FRAC_BITS = 14,
    parameter int COEF_WIDTH     = 20
) (
    input  logic                           aclk,
    input  logic                           en_mul,
    input  logic                           en_sum,
    input  logic [vta_pkg::CFG_W-1:0]      coef,
    input  vta_pkg::rel_vec_t              rel,
    output vta_pkg::pos_t                  tr_value
);
    import vta_pkg::*;

    localparam int EXT_W  = NUM_AXES * COEF_WIDTH;
    localparam int PROD_W = REL_W + COEF_WIDTH;
    localparam int SUM_W  = PROD_W + 2;
    localparam logic [SUM_W-1:0] FRAC_MASK =
        SUM_W'((64'd1 << COEF_FRAC_BITS) - 64'd1);

    logic [EXT_W-1:0]         coef_ext;
    logic signed [COEF_WIDTH-1:0] coef_k [NUM_AXES];
    logic signed [PROD_W-1:0] prod_next [NUM_AXES];
    logic signed [PROD_W-1:0] prod_reg [NUM_AXES];
    logic signed [SUM_W-1:0]  sum;
    logic signed [SUM_W-1:0]  sum_adj;
    logic signed [SUM_W-1:0]  quot;
    pos_t                     tr_next;
    pos_t                     tr_reg;

    // Bits of the last coefficient that lie beyond the register read as zero.
    assign coef_ext = EXT_W'(coef);

    always_comb begin
        for (int k = 0; k < NUM_AXES; k++) begin
            coef_k[k]    = $signed(coef_ext[k*COEF_WIDTH +: COEF_WIDTH]);
            prod_next[k] = $signed(rel[k]) * coef_k[k];
        end
    end

    always_ff @(posedge aclk) begin
        if (en_mul) begin
            for (int k = 0; k < NUM_AXES; k++) begin
                prod_reg[k] <= prod_next[k];
            end
        end
    end

    // Truncation toward zero: negative sums are biased up before the shift.
    always_comb begin
        sum = SUM_W'(prod_reg[0]) + SUM_W'(prod_reg[1]) + SUM_W'(prod_reg[2]);
        sum_adj = sum + (sum[SUM_W-1] ? $signed(FRAC_MASK) : $signed({SUM_W{1'b0}}));
        quot = sum_adj >>> COEF_FRAC_BITS;
        tr_next = POS_W'(quot);
    end

    always_ff @(posedge aclk) begin
        if (en_sum) begin
            tr_reg <= tr_next;
        end
    end

    assign tr_value = tr_reg;

endmodule

@@ hdl/vta_accum.sv @@
module vta_accum (
    input  logic               aclk,
    input  logic               aresetn,
    input  vta_pkg::acc_ctl_t  ctl,
    input  vta_pkg::rel_vec_t  rel,
    input  vta_pkg::pos_vec_t  tr,
    output vta_pkg::pos_vec_t  pos
);
    import vta_pkg::*;

    pos_t last_reg [NUM_AXES];
    pos_t row_reg [NUM_AXES];
    pos_t pos_next [NUM_AXES];
    pos_t row_next [NUM_AXES];
    pos_vec_t out_reg;

    always_comb begin
        for (int k = 0; k < NUM_AXES; k++) begin
            row_next[k] = row_reg[k];
            unique case (ctl.kind)
                KIND_CONTINUE: begin
                    pos_next[k] = last_reg[k] + tr[k];
                end
                KIND_NEW_ROW: begin
                    pos_next[k] = row_reg[k] + tr[k];
                    row_next[k] = pos_next[k];
                end
                default: begin
                    // Origin load; the unused kind decodes the same way.
                    pos_next[k] = POS_W'($signed(rel[k]));
                    row_next[k] = pos_next[k];
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < NUM_AXES; k++) begin
                last_reg[k] <= '0;
                row_reg[k]  <= '0;
            end
        end else if (ctl.load) begin
            for (int k = 0; k < NUM_AXES; k++) begin
                last_reg[k] <= pos_next[k];
                row_reg[k]  <= row_next[k];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.load) begin
            for (int k = 0; k < NUM_AXES; k++) begin
                out_reg[k] <= pos_next[k];
            end
        end
    end

    assign pos = out_reg;

endmodule

@@ hdl/vector_transform_accumulate_core.sv @@
// Vector transform and accumulate core.
//
// Each item on the slave stream is a relative offset vector (x, y, z) with a
// position kind in tuser. The offset is multiplied as a row vector by a 3x3
// matrix of signed fixed-point coefficients, each sum is truncated toward zero,
// and the result is added to the previous item's position (continue) or to the
// current row's first position (new row). An origin item loads its vector as
// the position directly. Every item yields one absolute position on the master
// stream; positions wrap at 32 bits.
//
// The matrix is written through the configuration port, one column register
// per write, and must only be changed while no item is in flight.
// From acceptance to m_tvalid an item passes the input register, the
// multiplier register and the sum register, then the accumulator drives the
// output register. Throughput is one item per cycle while m_tready stays high,
// set by the single accumulation step that closes the position feedback loop.
// A stalled receiver holds the output register; the stages behind it fill and
// then s_tready drops. Reset clears the pipeline valids, both stored positions
// to zero, and the matrix to identity.
module vector_transform_accumulate_core #(
    parameter int COEF_FRAC_BITS = 14,
    parameter int COEF_WIDTH     = 20
) (
    input  logic                              aclk,
    input  logic                              aresetn,

    input  logic                              cfg_wr_en,
    input  vta_pkg::cfg_idx_t                 cfg_wr_idx,
    input  logic [vta_pkg::CFG_W-1:0]         cfg_wr_data,

    input  logic                              s_tvalid,
    output logic                              s_tready,
    // s_tdata fields from bit 0: rel_x[15:0], rel_y[31:16], rel_z[47:32].
    input  logic [47:0]                       s_tdata,
    // s_tuser fields from bit 0: pos_kind[1:0].
    input  logic [1:0]                        s_tuser,

    output logic                              m_tvalid,
    input  logic                              m_tready,
    // m_tdata fields from bit 0: abs_x[31:0], abs_y[63:32], abs_z[95:64].
    output logic [95:0]                       m_tdata
);
    import vta_pkg::*;

    // Identity matrix at reset; anything beyond the register width is dropped.
    localparam logic [CFG_W-1:0] COEF_RESET_X = CFG_W'(64'd1 << COEF_FRAC_BITS);
    localparam logic [CFG_W-1:0] COEF_RESET_Y =
        CFG_W'((64'd1 << COEF_FRAC_BITS) << COEF_WIDTH);
    localparam logic [CFG_W-1:0] COEF_RESET_Z =
        CFG_W'((64'd1 << COEF_FRAC_BITS) << (2 * COEF_WIDTH));

    logic [CFG_W-1:0] coef_reg [NUM_AXES];

    // Pipeline state. Stage 1 is the input register, stage 2 holds the
    // products, stage 3 holds the truncated sums.
    logic      v1_reg, v2_reg, v3_reg, mv_reg;
    rel_vec_t  rel1_reg, rel2_reg, rel3_reg;
    pos_kind_t kind1_reg, kind2_reg, kind3_reg;

    logic      accept;
    logic      en_mul;
    logic      en_sum;
    logic      load_out;
    logic      free1, free2, free3;
    pos_vec_t  tr;
    pos_vec_t  pos;
    acc_ctl_t  acc_ctl;

    // Configuration writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coef_reg[0] <= COEF_RESET_X;
            coef_reg[1] <= COEF_RESET_Y;
            coef_reg[2] <= COEF_RESET_Z;
        end else if (cfg_wr_en) begin
            unique case (cfg_wr_idx)
                CFG_IDX_COL_X: coef_reg[0] <= cfg_wr_data;
                CFG_IDX_COL_Y: coef_reg[1] <= cfg_wr_data;
                CFG_IDX_COL_Z: coef_reg[2] <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    // Each stage moves forward when its successor is empty or moving too.
    assign load_out = v3_reg && (!mv_reg || m_tready);
    assign free3    = !v3_reg || load_out;
    assign en_sum   = v2_reg && free3;
    assign free2    = !v2_reg || free3;
    assign en_mul   = v1_reg && free2;
    assign free1    = !v1_reg || free2;
    assign s_tready = free1;
    assign accept   = s_tvalid && free1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            mv_reg <= 1'b0;
        end else begin
            if (accept) begin
                v1_reg <= 1'b1;
            end else if (en_mul) begin
                v1_reg <= 1'b0;
            end
            if (en_mul) begin
                v2_reg <= 1'b1;
            end else if (en_sum) begin
                v2_reg <= 1'b0;
            end
            if (en_sum) begin
                v3_reg <= 1'b1;
            end else if (load_out) begin
                v3_reg <= 1'b0;
            end
            if (load_out) begin
                mv_reg <= 1'b1;
            end else if (m_tready) begin
                mv_reg <= 1'b0;
            end
        end
    end

    // Payload that travels alongside the arithmetic.
    always_ff @(posedge aclk) begin
        if (accept) begin
            rel1_reg  <= rel_vec_t'(s_tdata);
            kind1_reg <= s_tuser;
        end
        if (en_mul) begin
            rel2_reg  <= rel1_reg;
            kind2_reg <= kind1_reg;
        end
        if (en_sum) begin
            rel3_reg  <= rel2_reg;
            kind3_reg <= kind2_reg;
        end
    end

    // One multiply-and-truncate column per output axis.
    for (genvar k = 0; k < NUM_AXES; k++) begin : g_col
        vta_column #(
            .COEF_FRAC_BITS (COEF_FRAC_BITS),
            .COEF_WIDTH     (COEF_WIDTH)
        ) u_column (
            .aclk     (aclk),
            .en_mul   (en_mul),
            .en_sum   (en_sum),
            .coef     (coef_reg[k]),
            .rel      (rel1_reg),
            .tr_value (tr[k])
        );
    end

    assign acc_ctl.load = load_out;
    assign acc_ctl.kind = kind3_reg;

    vta_accum u_accum (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (acc_ctl),
        .rel     (rel3_reg),
        .tr      (tr),
        .pos     (pos)
    );

    assign m_tvalid = mv_reg;
    assign m_tdata  = pos;

endmodule

@@ dv/vector_transform_accumulate_core_tb.sv @@
module vector_transform_accumulate_core_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import vta_pkg::*;

    // The testbench runs the core at its default coefficient format: Q6.14 in
    // 20-bit fields, three fields per 60-bit column register.
    localparam int COEF_FRAC_BITS = 14;
    localparam int COEF_WIDTH     = 20;

    // pos_kind 3 has no name in the package; the core decodes it in the same
    // default branch as an origin, so it must behave exactly like an origin load.
    localparam pos_kind_t KIND_UNUSED = 2'd3;

    // Column register patterns at the edges of the coefficient range.
    localparam logic [CFG_W-1:0] COL_ZERO     = 60'h0;
    localparam logic [CFG_W-1:0] COL_ALL_ONES = 60'hFFFFF_FFFFF_FFFFF;
    localparam logic [CFG_W-1:0] COL_MAX      = 60'h7FFFF_7FFFF_7FFFF;
    localparam logic [CFG_W-1:0] COL_MIN      = 60'h80000_80000_80000;

    // A quiet stretch this long, with no item moving on either side, means
    // the core has hung.
    localparam int WATCHDOG_LIMIT = 1000;

    logic                aclk        = 1'b0;
    logic                aresetn     = 1'b0;
    logic                cfg_wr_en   = 1'b0;
    cfg_idx_t            cfg_wr_idx  = CFG_IDX_COL_X;
    logic [CFG_W-1:0]    cfg_wr_data = '0;
    logic                s_tvalid    = 1'b0;
    logic                s_tready;
    // s_tdata fields from bit 0: rel_x[15:0], rel_y[31:16], rel_z[47:32].
    logic [47:0]         s_tdata     = '0;
    // s_tuser fields from bit 0: pos_kind[1:0].
    logic [1:0]          s_tuser     = '0;
    logic                m_tvalid;
    logic                m_tready    = 1'b0;
    // m_tdata fields from bit 0: abs_x[31:0], abs_y[63:32], abs_z[95:64].
    logic [95:0]         m_tdata;

    vector_transform_accumulate_core #(
        .COEF_FRAC_BITS (COEF_FRAC_BITS),
        .COEF_WIDTH     (COEF_WIDTH)
    ) u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_idx  (cfg_wr_idx),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Shadow copy of the core's state: the three matrix columns and the two
    // stored positions, kept in step with every write and every accepted item.
    logic [63:0] coef_cols [NUM_AXES];
    pos_vec_t    last_pos;
    pos_vec_t    row_start_pos;

    // Positions still owed by the core, oldest first.
    pos_vec_t    expected_pos [$];

    int          mismatches       = 0;
    int          results_seen     = 0;
    int          tx_no_idle_left  = 0;

    // One row of the directed table. When load_coef is set, all three columns
    // are loaded with coef before the item goes out. When typed is set, want
    // is the position read straight off the rules, and it is checked in place
    // of the predicted one.
    typedef struct {
        bit               load_coef;
        logic [CFG_W-1:0] coef;
        pos_kind_t        kind;
        rel_vec_t         rel;
        bit               typed;
        pos_vec_t         want;
    } grid_row_t;

    function automatic rel_vec_t rel3(int x, int y, int z);
        return {rel_t'(z), rel_t'(y), rel_t'(x)};
    endfunction

    function automatic pos_vec_t pos3(int x, int y, int z);
        return {pos_t'(z), pos_t'(y), pos_t'(x)};
    endfunction

    function automatic logic [CFG_W-1:0] pack_col(int c0, int c1, int c2);
        logic [COEF_WIDTH-1:0] f0, f1, f2;
        f0 = c0[COEF_WIDTH-1:0];
        f1 = c1[COEF_WIDTH-1:0];
        f2 = c2[COEF_WIDTH-1:0];
        return {f2, f1, f0};
    endfunction

    function automatic void reset_shadow();
        coef_cols[0] = 64'(1) << COEF_FRAC_BITS;
        coef_cols[1] = (64'(1) << COEF_FRAC_BITS) << COEF_WIDTH;
        coef_cols[2] = (64'(1) << COEF_FRAC_BITS) << (2 * COEF_WIDTH);
        last_pos      = '0;
        row_start_pos = '0;
    endfunction

    // Dot product of the offset with one matrix column. The sum is exact in
    // 64 bits; signed division truncates toward zero, which is the rounding
    // the core applies before keeping the low 32 bits.
    function automatic pos_t column_transform(rel_vec_t rel, logic [63:0] col);
        longint                       acc;
        longint                       coef;
        longint                       offs;
        logic signed [COEF_WIDTH-1:0] field;
        logic signed [REL_W-1:0]      r;
        logic [63:0]                  shifted;
        int                           m;
        acc = 0;
        for (m = 0; m < NUM_AXES; m++) begin
            shifted = col >> (m * COEF_WIDTH);
            field   = shifted[COEF_WIDTH-1:0];
            coef    = field;
            r       = rel[m];
            offs    = r;
            acc    += offs * coef;
        end
        acc = acc / (longint'(1) << COEF_FRAC_BITS);
        return acc[POS_W-1:0];
    endfunction

    // Advances the shadow state by one accepted item and returns the
    // position the core must produce for it.
    function automatic pos_vec_t predict_position(pos_kind_t kind, rel_vec_t rel);
        pos_vec_t                pos;
        logic signed [REL_W-1:0] r;
        int                      k;
        for (k = 0; k < NUM_AXES; k++) begin
            if (kind == KIND_ORIGIN || kind == KIND_UNUSED) begin
                r                = rel[k];
                pos[k]           = pos_t'(r);
                row_start_pos[k] = pos[k];
            end else if (kind == KIND_NEW_ROW) begin
                pos[k]           = row_start_pos[k] + column_transform(rel, coef_cols[k]);
                row_start_pos[k] = pos[k];
            end else begin
                pos[k] = last_pos[k] + column_transform(rel, coef_cols[k]);
            end
        end
        last_pos = pos;
        return pos;
    endfunction

    // Idle length for either side: mostly none or short, now and then long.
    function automatic int pick_idle();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    // Offsets lean toward small steps, as a real grid does, with full-range
    // values and the field extremes mixed in.
    function automatic rel_t pick_offset();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return rel_t'($urandom_range(0, 127) - 64);
        else if (r < 75)
            return rel_t'($urandom);
        else begin
            case ($urandom_range(0, 3))
                0:       return 16'h8000;
                1:       return 16'h7FFF;
                2:       return 16'h0000;
                default: return 16'hFFFF;
            endcase
        end
    endfunction

    function automatic rel_vec_t pick_rel();
        return {pick_offset(), pick_offset(), pick_offset()};
    endfunction

    function automatic int pick_extreme_coef();
        case ($urandom_range(0, 5))
            0:       return 'h80000;
            1:       return 'h7FFFF;
            2:       return 0;
            3:       return -1;
            4:       return 1;
            default: return 1 << COEF_FRAC_BITS;
        endcase
    endfunction

    task automatic report_mismatch(string what, pos_t got, pos_t want);
        $display("MISMATCH result %0d %s: got %0d, expected %0d",
                 results_seen, what, $signed(got), $signed(want));
        mismatches++;
    endtask

    // All tasks below are entered and left just after a falling edge, which
    // is where every input of the core changes.

    task automatic send_item(pos_kind_t kind, rel_vec_t rel, bit typed, pos_vec_t want);
        int       gap;
        pos_vec_t pred;
        if (tx_no_idle_left > 0) begin
            gap = 0;
            tx_no_idle_left--;
        end else begin
            gap = pick_idle();
            if ($urandom_range(0, 99) < 3)
                tx_no_idle_left = 40;
        end
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = rel;
        s_tuser  = kind;
        do @(posedge aclk); while (!s_tready);
        pred = predict_position(kind, rel);
        expected_pos.push_back(typed ? want : pred);
        @(negedge aclk);
    endtask

    // Holds the sender off until every owed position has come out. The core
    // emits one result per item, so an empty queue means an empty pipeline.
    task automatic wait_drained();
        s_tvalid = 1'b0;
        while (expected_pos.size() != 0)
            @(negedge aclk);
    endtask

    task automatic put_column(cfg_idx_t idx, logic [CFG_W-1:0] value);
        cfg_wr_en   = 1'b1;
        cfg_wr_idx  = idx;
        cfg_wr_data = value;
        @(negedge aclk);
        coef_cols[idx] = value;
    endtask

    task automatic load_matrix(logic [CFG_W-1:0] cx, logic [CFG_W-1:0] cy,
                               logic [CFG_W-1:0] cz);
        wait_drained();
        put_column(CFG_IDX_COL_X, cx);
        put_column(CFG_IDX_COL_Y, cy);
        put_column(CFG_IDX_COL_Z, cz);
        cfg_wr_en = 1'b0;
    endtask

    // Mostly well-formed grid traffic: an occasional origin, then a row that
    // opens with a new-row item and runs on with continue items. A few items
    // carry a random kind and a full-range offset. Once in a while the sender
    // waits for the core to drain completely.
    task automatic run_grid_rows(int count);
        int done;
        int row_len;
        done = 0;
        while (done < count) begin
            if ($urandom_range(0, 99) < 8) begin
                send_item(pos_kind_t'($urandom_range(0, 3)),
                          rel_vec_t'(48'({$urandom, $urandom})), 1'b0, '0);
                done++;
            end else begin
                if ($urandom_range(0, 99) < 30) begin
                    send_item($urandom_range(0, 1) ? KIND_ORIGIN : KIND_UNUSED, pick_rel(),
                              1'b0, '0);
                    done++;
                end
                send_item(KIND_NEW_ROW, pick_rel(), 1'b0, '0);
                done++;
                row_len = $urandom_range(0, 12);
                repeat (row_len) send_item(KIND_CONTINUE, pick_rel(), 1'b0, '0);
                done += row_len;
            end
            if ($urandom_range(0, 199) == 0)
                wait_drained();
        end
    endtask

    // Result side: ready runs of random length, usually short, sometimes a
    // long unbroken stretch, separated by stalls drawn like the sender's gaps.
    initial begin
        int run;
        int stall;
        forever begin
            run   = ($urandom_range(0, 99) < 8) ? $urandom_range(100, 300)
                                                : $urandom_range(1, 16);
            stall = pick_idle();
            @(negedge aclk);
            m_tready = 1'b1;
            repeat (run - 1) @(negedge aclk);
            if (stall > 0) begin
                @(negedge aclk);
                m_tready = 1'b0;
                repeat (stall - 1) @(negedge aclk);
            end
        end
    end

    // Every position leaving the core is compared, axis by axis, with the
    // oldest one owed. Values are read at the rising edge, before the core
    // updates its outputs for the next cycle.
    always @(posedge aclk) begin
        pos_vec_t got;
        pos_vec_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata;
            if (expected_pos.size() == 0) begin
                report_mismatch("abs_x with no item pending", got[0], '0);
            end else begin
                want = expected_pos.pop_front();
                if (got[0] !== want[0]) report_mismatch("abs_x", got[0], want[0]);
                if (got[1] !== want[1]) report_mismatch("abs_y", got[1], want[1]);
                if (got[2] !== want[2]) report_mismatch("abs_z", got[2], want[2]);
            end
            results_seen++;
        end
    end

    // Ends the run if nothing moves on either stream for too long.
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Verification failed");
        $finish;
    end

    initial begin
        grid_row_t directed_rows [18];
        int        i;
        int        phase;

        // Identity matrix after reset: positions are plain sums of offsets,
        // so every expectation here can be written down directly. The rows
        // cover both field extremes, each kind, the unused kind and a new row
        // taking its base from the row start rather than the last point.
        directed_rows[0]  = '{0, COL_ZERO, KIND_CONTINUE, rel3(1, 2, 3), 1,
                              pos3(1, 2, 3)};
        directed_rows[1]  = '{0, COL_ZERO, KIND_ORIGIN, rel3(32767, -32768, -1), 1,
                              pos3(32767, -32768, -1)};
        directed_rows[2]  = '{0, COL_ZERO, KIND_CONTINUE, rel3(32767, 32767, 32767), 1,
                              pos3(65534, -1, 32766)};
        directed_rows[3]  = '{0, COL_ZERO, KIND_NEW_ROW, rel3(-32768, 0, 1), 1,
                              pos3(-1, -32768, 0)};
        directed_rows[4]  = '{0, COL_ZERO, KIND_CONTINUE, rel3(0, 0, 0), 1,
                              pos3(-1, -32768, 0)};
        directed_rows[5]  = '{0, COL_ZERO, KIND_UNUSED, rel3(-32768, 32767, 0), 1,
                              pos3(-32768, 32767, 0)};
        directed_rows[6]  = '{0, COL_ZERO, KIND_NEW_ROW, rel3(1, 1, 1), 1,
                              pos3(-32767, 32768, 1)};
        directed_rows[7]  = '{0, COL_ZERO, KIND_ORIGIN, rel3(0, 0, 0), 1,
                              pos3(0, 0, 0)};
        // Every coefficient at the smallest negative step: the sums are tiny
        // negative or positive fractions, and truncation toward zero (not
        // floor) decides the result.
        directed_rows[8]  = '{1, COL_ALL_ONES, KIND_CONTINUE, rel3(1, 0, 0), 1,
                              pos3(0, 0, 0)};
        directed_rows[9]  = '{0, COL_ZERO, KIND_CONTINUE, rel3(-32768, -32768, -32768), 1,
                              pos3(6, 6, 6)};
        directed_rows[10] = '{0, COL_ZERO, KIND_CONTINUE, rel3(32767, 32767, 32767), 1,
                              pos3(1, 1, 1)};
        // Most negative coefficients against most negative offsets give the
        // widest products the datapath has to hold.
        directed_rows[11] = '{1, COL_MIN, KIND_ORIGIN, rel3(0, 0, 0), 1,
                              pos3(0, 0, 0)};
        directed_rows[12] = '{0, COL_ZERO, KIND_CONTINUE, rel3(-32768, -32768, -32768), 1,
                              pos3(3145728, 3145728, 3145728)};
        directed_rows[13] = '{0, COL_ZERO, KIND_NEW_ROW, rel3(32767, 32767, 32767), 1,
                              pos3(-3145632, -3145632, -3145632)};
        // Largest positive coefficients; these rows are left to the predictor.
        directed_rows[14] = '{1, COL_MAX, KIND_CONTINUE, rel3(32767, -32768, 32767), 0,
                              '0};
        directed_rows[15] = '{0, COL_ZERO, KIND_CONTINUE, rel3(-1, -1, -1), 0, '0};
        directed_rows[16] = '{0, COL_ZERO, KIND_NEW_ROW, rel3(-32768, 32767, -32768), 0,
                              '0};
        directed_rows[17] = '{0, COL_ZERO, KIND_CONTINUE, rel3(-32768, -32768, -32768), 0,
                              '0};

        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        reset_shadow();

        for (i = 0; i < 18; i++) begin
            if (directed_rows[i].load_coef)
                load_matrix(directed_rows[i].coef, directed_rows[i].coef,
                            directed_rows[i].coef);
            send_item(directed_rows[i].kind, directed_rows[i].rel,
                      directed_rows[i].typed, directed_rows[i].want);
        end

        // Random grid traffic under a series of matrices, from small
        // rotation-like coefficients through the register extremes to fully
        // random column words. Each change waits for the core to go idle.
        for (phase = 0; phase < 8; phase++) begin
            case (phase)
                0: load_matrix(pack_col($urandom_range(0, 65535) - 32768,
                                        $urandom_range(0, 65535) - 32768,
                                        $urandom_range(0, 65535) - 32768),
                               pack_col($urandom_range(0, 65535) - 32768,
                                        $urandom_range(0, 65535) - 32768,
                                        $urandom_range(0, 65535) - 32768),
                               pack_col($urandom_range(0, 65535) - 32768,
                                        $urandom_range(0, 65535) - 32768,
                                        $urandom_range(0, 65535) - 32768));
                1: load_matrix(COL_ZERO, COL_ZERO, COL_ZERO);
                2: load_matrix(COL_ALL_ONES, COL_ALL_ONES, COL_ALL_ONES);
                3: load_matrix(COL_MAX, COL_MIN, COL_MAX);
                4: load_matrix(COL_MIN, COL_MAX, COL_MIN);
                5: load_matrix(pack_col(pick_extreme_coef(), pick_extreme_coef(),
                                        pick_extreme_coef()),
                               pack_col(pick_extreme_coef(), pick_extreme_coef(),
                                        pick_extreme_coef()),
                               pack_col(pick_extreme_coef(), pick_extreme_coef(),
                                        pick_extreme_coef()));
                default: load_matrix(CFG_W'({$urandom, $urandom}),
                                     CFG_W'({$urandom, $urandom}),
                                     CFG_W'({$urandom, $urandom}));
            endcase
            run_grid_rows(70);
        end

        // A long run of large positive steps under the largest coefficients
        // drives every axis past the top of the signed 32-bit range, so the
        // accumulator has to wrap.
        load_matrix(COL_MAX, COL_MAX, COL_MAX);
        send_item(KIND_ORIGIN, rel3(0, 0, 0), 1'b0, '0);
        repeat (780)
            send_item(KIND_CONTINUE, rel3($urandom_range(30000, 32767),
                                          $urandom_range(30000, 32767),
                                          $urandom_range(30000, 32767)), 1'b0, '0);

        // Drain, then leave a few cycles for any stray result to show up.
        wait_drained();
        repeat (8) @(negedge aclk);
        if (mismatches == 0 && expected_pos.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

@@ sim.f @@
hdl/vta_pkg.sv
hdl/vta_column.sv
hdl/vta_accum.sv
hdl/vector_transform_accumulate_core.sv
dv/vector_transform_accumulate_core_tb.sv
